/* rtl/sbh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sbh_pkg;

   // Defaults for the top-level parameters.
   localparam int MaxBucketsDefault = 256;
   localparam int CountBitsDefault  = 32;

   // Configuration register layout.
   localparam int CfgBucketWidth  = 9;
   localparam logic [CfgBucketWidth-1:0] CfgBucketReset = 9'd256;
   localparam int CsrAddrWidth    = 3;
   localparam logic [CsrAddrWidth-1:0] CsrAddrBucketCount = 3'd0;

   // Command codes as they arrive on the request channel.
   localparam logic [1:0] CmdLoad     = 2'd0;
   localparam logic [1:0] CmdClassify = 2'd1;
   localparam logic [1:0] CmdRead     = 2'd2;
   localparam logic [1:0] CmdClear    = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CLASSIFY,
      OP_READ,
      OP_CLEAR
   } sbh_op_type;

   // One decoded item as it travels from the front to the back.
   typedef struct packed {
      sbh_op_type  op;
      logic [7:0]  slot;
      logic [31:0] key;
   } sbh_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_DONE
   } sbh_state_type;

   // IEEE-754 single precision "a < b"; false whenever either side is NaN.
   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic res;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
         res = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         res = 1'b0;
      end else if (a[31] && !b[31]) begin
         res = 1'b1;
      end else if (!a[31] && b[31]) begin
         res = 1'b0;
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* rtl/sbh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

/* rtl/sbh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module sbh_front
   import sbh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [1:0]   in_cmd,
   input  wire logic [7:0]   in_slot,
   input  wire logic [31:0]  in_key,
   output logic              out_valid,
   input  wire logic         out_ready,
   output sbh_item_type      out_item
);

   sbh_item_type q_ff [2];
   sbh_item_type q_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push, pop;

   // Decode the command code into an operation.
   always_comb begin
      q_in.slot = in_slot;
      q_in.key  = in_key;
      unique case (in_cmd)
         CmdLoad:     q_in.op = OP_LOAD;
         CmdClassify: q_in.op = OP_CLASSIFY;
         CmdRead:     q_in.op = OP_READ;
         CmdClear:    q_in.op = OP_CLEAR;
         default:     q_in.op = OP_CLEAR;
      endcase
   end

   // Two-entry queue between the request channel and the back end.
   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/sbh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module sbh_back
   import sbh_pkg::*;
#(
   parameter int MAX_BUCKETS = MaxBucketsDefault,
   parameter int COUNT_BITS  = CountBitsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [CfgBucketWidth-1:0] bucket_count,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire sbh_item_type              in_item,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic      [7:0]                out_bucket,
   output logic      [31:0]               out_total
);

   localparam int AW = $clog2(MAX_BUCKETS);
   localparam logic [CfgBucketWidth-1:0] MaxN = CfgBucketWidth'(MAX_BUCKETS);

   sbh_state_type    state_ff, state_in;
   sbh_item_type     item_ff, item_in;
   logic [7:0]       idx_ff, idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [7:0]       bucket_ff, bucket_in;
   logic [31:0]      total_ff, total_in;
   logic             out_vld_ff, out_vld_in;
   logic [7:0]       out_bucket_ff, out_bucket_in;
   logic [31:0]      out_total_ff, out_total_in;
   logic [MAX_BUCKETS-1:0] cnt_vld_ff, cnt_vld_in;

   logic [CfgBucketWidth-1:0] n_clamp;
   logic [7:0]       n_m1;
   logic             slot_ok;
   logic             sp_we;
   logic [31:0]      sp_rdata;
   logic             cnt_we;
   logic [COUNT_BITS-1:0] cnt_rdata, cnt_cur, cnt_new;
   logic [63:0]      cnt_wide;
   logic             out_free;

   // Buckets in use, clamped to the supported range.
   always_comb begin
      if (bucket_count < 9'd2) begin
         n_clamp = 9'd2;
      end else if (bucket_count > MaxN) begin
         n_clamp = MaxN;
      end else begin
         n_clamp = bucket_count;
      end
      n_m1 = 8'(n_clamp - 9'd1);
   end

   assign slot_ok  = (CfgBucketWidth'(in_item.slot) < MaxN);
   assign out_free = !out_vld_ff || out_ready;
   assign in_ready = (state_ff == ST_IDLE);
   assign sp_we    = in_valid && in_ready && (in_item.op == OP_LOAD) && slot_ok;

   sbh_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_split_ram (
      .clock (clock),
      .we    (sp_we),
      .waddr (in_item.slot[AW-1:0]),
      .wdata (in_item.key),
      .raddr (idx_ff[AW-1:0]),
      .rdata (sp_rdata)
   );

   sbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BUCKETS)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (bucket_ff[AW-1:0]),
      .wdata (cnt_new),
      .raddr (bucket_ff[AW-1:0]),
      .rdata (cnt_rdata)
   );

   // Count read-modify-write: an entry that is not valid reads as zero.
   always_comb begin
      cnt_cur = cnt_vld_ff[bucket_ff[AW-1:0]] ? cnt_rdata : '0;
      cnt_new = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
      if (item_ff.op == OP_CLASSIFY) begin
         cnt_wide = 64'(cnt_new);
      end else begin
         cnt_wide = 64'(cnt_cur);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               unique case (in_item.op)
                  OP_CLASSIFY: state_in = ST_SCAN;
                  OP_READ:     state_in = slot_ok ? ST_CNT_RD : ST_DONE;
                  OP_LOAD,
                  OP_CLEAR:    state_in = ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN:   state_in = (idx_ff == n_m1) ? ST_DRAIN : ST_SCAN;
         ST_DRAIN:  state_in = ST_CNT_RD;
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: state_in = ST_DONE;
         ST_DONE:   state_in = out_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      item_in       = item_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      bucket_in     = bucket_ff;
      total_in      = total_ff;
      cnt_vld_in    = cnt_vld_ff;
      cnt_we        = 1'b0;
      out_vld_in    = out_vld_ff && !out_ready;
      out_bucket_in = out_bucket_ff;
      out_total_in  = out_total_ff;

      // Compare the splitter read in the previous cycle.
      if (cmp_vld_ff && !flt_lt(item_ff.key, sp_rdata)) begin
         bucket_in = bucket_ff + 8'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               item_in   = in_item;
               idx_in    = 8'd1;
               bucket_in = (in_item.op == OP_CLASSIFY) ? 8'd0 : in_item.slot;
               total_in  = 32'd0;
               if (in_item.op == OP_CLEAR) begin
                  cnt_vld_in = '0;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (idx_ff != n_m1) begin
               idx_in = idx_ff + 8'd1;
            end
         end
         ST_CNT_WR: begin
            if (item_ff.op == OP_CLASSIFY) begin
               cnt_we = 1'b1;
               cnt_vld_in[bucket_ff[AW-1:0]] = 1'b1;
            end
            total_in = (|cnt_wide[63:32]) ? 32'hFFFF_FFFF : cnt_wide[31:0];
         end
         ST_DONE: begin
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_bucket_in = bucket_ff;
               out_total_in  = total_ff;
            end
         end
         ST_DRAIN,
         ST_CNT_RD: begin
         end
         default: begin
         end
      endcase
   end

   assign out_valid  = out_vld_ff;
   assign out_bucket = out_bucket_ff;
   assign out_total  = out_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         cnt_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
         cnt_vld_ff <= cnt_vld_in;
      end
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      bucket_ff     <= bucket_in;
      total_ff      <= total_in;
      out_bucket_ff <= out_bucket_in;
      out_total_ff  <= out_total_in;
   end

endmodule
`default_nettype wire

/* rtl/splitter_bucket_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sample-sort bucket classifier with a per-bucket histogram. A request carries
// a command in req_tuser: load a splitter into slot, classify a float key,
// read the count of bucket slot, or clear the histogram; every request gives
// exactly one response; for a classify or read it holds the bucket and its
// count. A two-entry queue takes requests while the back end works.
// Classification reads splitters 1 to n-1 from the splitter memory one per
// cycle and counts those the key is not below, so splitters need not be
// sorted; that single read port sets the pace of a classify. The histogram is
// cleared through per-bucket valid bits, so no clearing pass follows reset.
module splitter_bucket_histogram
   import sbh_pkg::*;
#(
   parameter int MAX_BUCKETS = MaxBucketsDefault,
   parameter int COUNT_BITS  = CountBitsDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [39:0]             req_tdata,   // slot[7:0], key_bits[39:8]
   input  wire logic [1:0]              req_tuser,   // command[1:0]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [39:0]             rsp_tdata,   // bucket[7:0], bucket_total[39:8]
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready
);

   logic [CfgBucketWidth-1:0] bucket_count_ff, bucket_count_in;
   logic                      cfg_sel;
   logic                      q_valid, q_ready;
   sbh_item_type              q_item;
   logic [7:0]                rsp_bucket;
   logic [31:0]               rsp_total;

   // Configuration register: bucket_count.
   assign csr_pready = 1'b1;
   assign cfg_sel    = (csr_paddr[CsrAddrWidth-1:2] == CsrAddrBucketCount[CsrAddrWidth-1:2]);

   always_comb begin
      bucket_count_in = bucket_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && cfg_sel) begin
         bucket_count_in = csr_pwdata[CfgBucketWidth-1:0];
      end
      csr_prdata = cfg_sel ? 32'(bucket_count_ff) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= CfgBucketReset;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   sbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_slot   (req_tdata[7:0]),
      .in_key    (req_tdata[39:8]),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   sbh_back #(.MAX_BUCKETS(MAX_BUCKETS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_item      (q_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_bucket   (rsp_bucket),
      .out_total    (rsp_total)
   );

   assign rsp_tdata = {rsp_total, rsp_bucket};

endmodule
`default_nettype wire
